### hw/rtl/postfix_expression_evaluator_core_assert.svh
// Assertion macros for the postfix evaluator.
// Used by postfix_expression_evaluator_core; needs clk and arst_n in scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PEE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define PEE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/pee_pkg.sv
// Package for the postfix evaluator: character codes and operation kinds.
// No dependencies.
package pee_pkg;
	localparam logic [7:0] ChPow = 8'h5E;
	localparam logic [7:0] ChMul = 8'h2A;
	localparam logic [7:0] ChDiv = 8'h2F;
	localparam logic [7:0] ChMod = 8'h25;
	localparam logic [7:0] ChAdd = 8'h2B;
	localparam logic [7:0] ChSub = 8'h2D;
	localparam logic [7:0] ChZero = 8'h30;

	typedef enum logic [2:0] {
		OP_NONE, OP_POW, OP_MUL, OP_DIV, OP_MOD, OP_ADD, OP_SUB
	} op_t;
endpackage

### hw/rtl/postfix_expression_evaluator_core.sv
// Postfix evaluator top level: operand stack in a synchronous RAM, a multi-cycle
// multiply unit shared by * and ^, a divider. Depends on pee_pkg and the assert header.
//
// channel | dir | tdata (low bit up)         | tuser / tlast
// s_axis  | in  | symbol[7:0]                | tlast = end_of_expression
// m_axis  | out | value[31:0]                | tuser = {divide_error, stack_underflowed,
//         |     |                            |          stack_overflowed}
// Operand character: pushed directly. + and -: two RAM pops, add or subtract, push.
// Unknown character: two RAM pops, no push. * , / and % : one multiplier or quotient bit
// per cycle; a zero divisor skips the divide. ^ : up to 61 shift-add multiplies.
// End of expression adds a final pop and then the result beat.
// Reset clears state, count, flags and tvalid only; stack RAM is read one entry per cycle.
// A stalled output beat holds s_axis_tready low until it is taken.
`include "postfix_expression_evaluator_core_assert.svh"

module postfix_expression_evaluator_core
	import pee_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
	input  logic        s_axis_tlast,   // end_of_expression
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // value[31:0]
	output logic [2:0]  m_axis_tuser    // stack_overflowed, stack_underflowed, divide_error
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_POPR, ST_POPR_W, ST_POPL, ST_POPL_W, ST_CALC, ST_MUL, ST_DIV,
		ST_PUSH, ST_FIN, ST_FIN_W, ST_OUT
	} state_t;

	logic [31:0] mem_q [STACK_DEPTH];
	logic [31:0] rd_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata;

	state_t      state_q;
	logic [CW-1:0] count_q;
	logic        ovf_q, unf_q, dz_q;
	op_t         op_q;
	logic        last_q;
	logic [31:0] right_q, left_q, res_q;
	logic        pop_ok_q;
	// power / multiply / divide working registers
	logic [31:0] acc_q, sq_q, ex_q, ma_q, mb_q, mp_q;
	logic [4:0]  pbit_q;
	logic        msel_q;   // 0: acc*sq step, 1: sq*sq step
	logic [5:0]  it_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [32:0] rsub;
	logic        is_alnum;
	op_t         op_d;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd_q <= mem_q[raddr];
	end

	always_comb begin
		logic [7:0] c;
		c = s_axis_tdata;
		is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
		case (c)
			ChPow: op_d = OP_POW;
			ChMul: op_d = OP_MUL;
			ChDiv: op_d = OP_DIV;
			ChMod: op_d = OP_MOD;
			ChAdd: op_d = OP_ADD;
			ChSub: op_d = OP_SUB;
			default: op_d = OP_NONE;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign raddr = AW'(count_q - CW'(1));
	assign rsub = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_comb begin
		we = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = res_q;
		if (state_q == ST_IDLE && s_axis_tvalid && is_alnum && count_q < DepthC) begin
			we = 1'b1;
			wdata = 32'(s_axis_tdata - ChZero);
		end else if (state_q == ST_PUSH && count_q < DepthC) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			unf_q <= 1'b0;
			dz_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					last_q <= s_axis_tlast;
					op_q <= op_d;
					if (is_alnum) begin
						if (count_q < DepthC) count_q <= count_q + CW'(1);
						else ovf_q <= 1'b1;
						state_q <= s_axis_tlast ? ST_FIN : ST_IDLE;
					end else begin
						state_q <= ST_POPR;
					end
				end
				ST_POPR, ST_POPL, ST_FIN: begin
					// raddr already addresses top; data arrives next cycle
					if (count_q == '0) begin
						unf_q <= 1'b1;
						pop_ok_q <= 1'b0;
					end else begin
						pop_ok_q <= 1'b1;
						count_q <= count_q - CW'(1);
					end
					state_q <= (state_q == ST_POPR) ? ST_POPR_W :
						(state_q == ST_POPL) ? ST_POPL_W : ST_FIN_W;
				end
				ST_POPR_W: begin
					right_q <= pop_ok_q ? rd_q : '0;
					state_q <= ST_POPL;
				end
				ST_POPL_W: begin
					left_q <= pop_ok_q ? rd_q : '0;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_PUSH;
					unique case (op_q)
						OP_ADD: res_q <= left_q + right_q;
						OP_SUB: res_q <= left_q - right_q;
						OP_MUL: begin
							ex_q <= 32'h1; acc_q <= 32'h0; sq_q <= left_q;
							ma_q <= left_q; mb_q <= right_q; mp_q <= '0;
							it_q <= '0; pbit_q <= 5'd30; msel_q <= 1'b0;
							state_q <= ST_MUL;
						end
						OP_POW: begin
							if (right_q[31]) begin
								if (left_q == 32'h1) res_q <= 32'h1;
								else if (left_q == 32'hFFFF_FFFF)
									res_q <= right_q[0] ? 32'hFFFF_FFFF : 32'h1;
								else res_q <= '0;
							end else begin
								acc_q <= 32'h1; sq_q <= left_q; ex_q <= right_q;
								ma_q <= 32'h1; mb_q <= left_q; mp_q <= '0;
								it_q <= '0; pbit_q <= '0; msel_q <= 1'b0;
								state_q <= ST_MUL;
							end
						end
						OP_DIV, OP_MOD: begin
							if (right_q == '0) begin
								dz_q <= 1'b1;
								res_q <= '0;
							end else begin
								rem_q <= '0;
								quo_q <= left_q[31] ? -left_q : left_q;
								dvs_q <= right_q[31] ? -right_q : right_q;
								it_q <= '0;
								state_q <= ST_DIV;
							end
						end
						default: state_q <= last_q ? ST_FIN : ST_IDLE;
					endcase
				end
				ST_MUL: begin
					// shift-add multiply, one bit per cycle; power chains them
					if (it_q != 6'd32) begin
						if (mb_q[0]) mp_q <= mp_q + ma_q;
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
						it_q <= it_q + 6'd1;
					end else if (op_q == OP_MUL) begin
						res_q <= mp_q;
						state_q <= ST_PUSH;
					end else begin
						// power: bit pbit of ex selects acc*=sq, then sq*=sq
						if (!msel_q) begin
							if (ex_q[pbit_q]) acc_q <= mp_q;
							msel_q <= 1'b1;
							ma_q <= sq_q; mb_q <= sq_q;
						end else begin
							sq_q <= mp_q;
							msel_q <= 1'b0;
							pbit_q <= pbit_q + 5'd1;
							ma_q <= acc_q; mb_q <= mp_q;
						end
						mp_q <= '0;
						it_q <= '0;
						if (!msel_q && (pbit_q == 5'd30 || (ex_q >> (pbit_q + 5'd1)) == '0)) begin
							res_q <= ex_q[pbit_q] ? mp_q : acc_q;
							state_q <= ST_PUSH;
						end
					end
				end
				ST_DIV: begin
					if (it_q != 6'd32) begin
						if (!rsub[32]) rem_q <= rsub[31:0];
						else rem_q <= {rem_q[30:0], quo_q[31]};
						quo_q <= {quo_q[30:0], !rsub[32]};
						it_q <= it_q + 6'd1;
					end else begin
						if (op_q == OP_MOD) res_q <= left_q[31] ? -rem_q : rem_q;
						else res_q <= (left_q[31] != right_q[31]) ? -quo_q : quo_q;
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (count_q < DepthC) count_q <= count_q + CW'(1);
					else ovf_q <= 1'b1;
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN_W: begin
					m_axis_tdata <= pop_ok_q ? rd_q : '0;
					m_axis_tuser <= {dz_q, unf_q, ovf_q};
					m_axis_tvalid <= 1'b1;
					count_q <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PEE_ASSERT_IMP(a_count_range, 1'b1, count_q <= DepthC)
	`PEE_ASSERT_IMP(a_ready_no_out, s_axis_tready, !m_axis_tvalid)
	`PEE_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q)
	`PEE_ASSERT_NEXT(a_out_clears, m_axis_tvalid && m_axis_tready, count_q == '0)
endmodule

### bench/postfix_expression_evaluator_core_tb.sv
// Testbench for postfix_expression_evaluator_core: drives postfix characters as
// stream beats and checks each emitted result against an in-bench stack model.
// Depends on pee_pkg and the RTL only.
`timescale 1ns / 100ps

module postfix_expression_evaluator_core_tb;
	import pee_pkg::*;

	localparam int Depth = 64;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} char_beat_t;

	typedef struct packed {
		logic [31:0] value;
		logic        ovf;
		logic        unf;
		logic        dz;
	} eval_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	postfix_expression_evaluator_core #(.STACK_DEPTH(Depth)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	char_beat_t   pending_chars[$];
	eval_result_t expected_results[$];
	int           errors = 0;
	int           results_seen = 0;
	int           chars_sent = 0;
	bit           hold_sender = 1'b0;

	// stack model
	logic [31:0] model_stack[Depth];
	int          model_count = 0;
	logic        model_ovf = 1'b0, model_unf = 1'b0, model_dz = 1'b0;

	function automatic void model_push(logic [31:0] v);
		if (model_count >= Depth) begin
			model_ovf = 1'b1;
		end else begin
			model_stack[model_count] = v;
			model_count++;
		end
	endfunction

	function automatic logic [31:0] model_pop();
		if (model_count == 0) begin
			model_unf = 1'b1;
			return '0;
		end
		model_count--;
		return model_stack[model_count];
	endfunction

	function automatic logic [31:0] wrap_power(logic [31:0] b, logic [31:0] e);
		logic [31:0] acc;
		logic [31:0] sq;
		acc = 32'd1;
		sq = b;
		if (e[31]) begin
			if (b == 32'd1) return 32'd1;
			if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
			return '0;
		end
		for (int i = 0; i < 31; i++) begin
			if (e[i]) acc = acc * sq;
			sq = sq * sq;
		end
		return acc;
	endfunction

	function automatic logic [31:0] signed_divide(logic [31:0] l, logic [31:0] r, bit rem);
		logic [31:0] ml, mr, q, m;
		ml = l[31] ? -l : l;
		mr = r[31] ? -r : r;
		if (r == '0) begin
			model_dz = 1'b1;
			return '0;
		end
		q = ml / mr;
		m = ml % mr;
		if (rem) return l[31] ? -m : m;
		return (l[31] != r[31]) ? -q : q;
	endfunction

	function automatic bit is_operand_char(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void evaluate_char(char_beat_t b);
		logic [31:0] rhs, lhs;
		eval_result_t r;
		if (is_operand_char(b.symbol)) begin
			model_push(b.symbol - ChZero);
		end else begin
			rhs = model_pop();
			lhs = model_pop();
			case (b.symbol)
				ChPow: model_push(wrap_power(lhs, rhs));
				ChMul: model_push(lhs * rhs);
				ChDiv: model_push(signed_divide(lhs, rhs, 1'b0));
				ChMod: model_push(signed_divide(lhs, rhs, 1'b1));
				ChAdd: model_push(lhs + rhs);
				ChSub: model_push(lhs - rhs);
				default: ;
			endcase
		end
		if (b.last) begin
			r.value = model_pop();
			r.ovf = model_ovf;
			r.unf = model_unf;
			r.dz = model_dz;
			model_count = 0;
			expected_results.push_back(r);
		end
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				evaluate_char({s_axis_tdata, s_axis_tlast});
				chars_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_chars.size() > 0 && !hold_sender) begin
					char_beat_t b;
					b = pending_chars.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= b.symbol;
					s_axis_tlast <= b.last;
					send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int stall = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				eval_result_t want;
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: value %h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser[0] !== want.ovf) begin
						$error("stack_overflowed: expected %b, got %b", want.ovf, m_axis_tuser[0]);
						errors++;
					end
					if (m_axis_tuser[1] !== want.unf) begin
						$error("stack_underflowed: expected %b, got %b", want.unf, m_axis_tuser[1]);
						errors++;
					end
					if (m_axis_tuser[2] !== want.dz) begin
						$error("divide_error: expected %b, got %b", want.dz, m_axis_tuser[2]);
						errors++;
					end
				end
				stall = $urandom_range(0, 3);
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] any_operand();
		case ($urandom_range(0, 2))
			0: return 8'(ChZero + $urandom_range(0, 9));
			1: return 8'("A" + $urandom_range(0, 25));
			default: return 8'("a" + $urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] any_operator();
		case ($urandom_range(0, 5))
			0: return ChPow;
			1: return ChMul;
			2: return ChDiv;
			3: return ChMod;
			4: return ChAdd;
			default: return ChSub;
		endcase
	endfunction

	task automatic queue_expr(string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back({8'(s[i]), 1'(i == s.len() - 1)});
	endtask

	// well-formed postfix expression; occasionally noise or broken shape
	task automatic queue_random_expr();
		int depth;
		int n;
		int k;
		logic [7:0] c;
		depth = 0;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 19);
			if (k == 0) c = 8'($urandom_range(0, 255));
			else if (depth >= 2 && k > 9) c = any_operator();
			else c = any_operand();
			if (is_operand_char(c)) depth++;
			else depth = (depth >= 2) ? depth - 1 : 0;
			pending_chars.push_back({c, 1'b0});
		end
		while (depth > 1 && $urandom_range(0, 7) != 0) begin
			pending_chars.push_back({any_operator(), 1'b0});
			depth--;
		end
		pending_chars[$].last = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// operators, zero divisor, negative exponent, unknown character
		queue_expr("34+");
		queue_expr("34-");
		queue_expr("z9*");
		queue_expr("72/");
		queue_expr("72%");
		queue_expr("50/");
		queue_expr("50%");
		queue_expr("23^");
		queue_expr("00^");
		queue_expr("0z^");
		queue_expr("112-^");
		queue_expr("012-^");
		queue_expr("013-^");
		queue_expr("212-^");
		queue_expr("z~");
		pending_chars.push_back({8'hFF, 1'b1});
		pending_chars.push_back({8'h00, 1'b1});
		// wrapped power of an even base, divided by and modulo minus one
		queue_expr("2zz*z*z*z*z*zz*z*z*^01-/");
		queue_expr("2zz*z*z*z*z*zz*z*z*^01-%");
		queue_expr("z5^");
		// overflow: push one past the depth
		for (int i = 0; i <= Depth; i++)
			pending_chars.push_back({8'("0" + i % 10), 1'(i == Depth)});

		while (pending_chars.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		while (chars_sent < 1250) begin
			if (pending_chars.size() < 4) queue_random_expr();
			if (chars_sent > 600 && chars_sent < 620 && !hold_sender) begin
				// drain everything once before carrying on
				hold_sender = 1'b1;
				while (s_axis_tvalid || expected_results.size() > 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			@(posedge clk);
		end
		pending_chars.push_back({8'("1"), 1'b1});
		while (pending_chars.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d characters, checked %0d results (all operators, flags, stack limits).",
			chars_sent, results_seen);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

endmodule
